/* rtl/core/palette_fade_engine_unit_macros.svh */
`ifndef PALETTE_FADE_ENGINE_UNIT_MACROS_SVH
`define PALETTE_FADE_ENGINE_UNIT_MACROS_SVH

// check a condition at every clock edge outside reset
`define PALFE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("palette fade engine check failed");

// check that pre in one cycle implies post in the next
`define PALFE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("palette fade engine sequence check failed");

`endif

/* rtl/core/palfe_pkg.sv */
package palfe_pkg;

  localparam int LEVEL_W = 3;
  localparam int FRAME_W = 5;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd7;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 3'd0;

  typedef enum logic [2:0] {
    MODE_WR_TARGET    = 3'd0,
    MODE_WR_PRIMARY   = 3'd1,
    MODE_WR_SECONDARY = 3'd2,
    MODE_FADE_IN      = 3'd3,
    MODE_FADE_OUT     = 3'd4,
    MODE_FLASH_IN     = 3'd5,
    MODE_FLASH_OUT    = 3'd6,
    MODE_TICK         = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    KIND_IDLE      = 3'd0,
    KIND_FADE_IN   = 3'd1,
    KIND_FADE_OUT  = 3'd2,
    KIND_FLASH_IN  = 3'd3,
    KIND_FLASH_OUT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic               wr_target;
    logic               wr_primary;
    logic               wr_secondary;
    logic               fill;
    logic [LEVEL_W-1:0] fill_level;
    logic               issue;
    kind_t              run_kind;
    logic               run_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic advance;
    logic last_taken;
  } dp_status_t;

  function automatic rgb_t step_primary(kind_t kind, rgb_t cur, rgb_t goal);
    rgb_t nxt;
    nxt = cur;
    case (kind)
      KIND_FADE_IN: begin
        if (goal.b > cur.b) nxt.b = cur.b + 3'd1;
        else if (goal.g > cur.g) nxt.g = cur.g + 3'd1;
        else if (goal.r > cur.r) nxt.r = cur.r + 3'd1;
      end
      KIND_FLASH_IN: begin
        if (goal.b < cur.b) nxt.b = cur.b - 3'd1;
        else if (goal.g < cur.g) nxt.g = cur.g - 3'd1;
        else if (goal.r < cur.r) nxt.r = cur.r - 3'd1;
      end
      KIND_FADE_OUT: begin
        if (cur.r != LEVEL_MIN) nxt.r = cur.r - 3'd1;
        else if (cur.g != LEVEL_MIN) nxt.g = cur.g - 3'd1;
        else if (cur.b != LEVEL_MIN) nxt.b = cur.b - 3'd1;
      end
      KIND_FLASH_OUT: begin
        if (cur.r != LEVEL_MAX) nxt.r = cur.r + 3'd1;
        else if (cur.g != LEVEL_MAX) nxt.g = cur.g + 3'd1;
        else if (cur.b != LEVEL_MAX) nxt.b = cur.b + 3'd1;
      end
      default: nxt = cur;
    endcase
    return nxt;
  endfunction

  function automatic rgb_t step_secondary(kind_t kind, rgb_t cur);
    rgb_t nxt;
    nxt = cur;
    case (kind)
      KIND_FADE_OUT, KIND_FLASH_OUT: nxt = step_primary(kind, cur, cur);
      default: nxt = cur;
    endcase
    return nxt;
  endfunction

endpackage

/* rtl/core/palfe_cmd_if.sv */
interface palfe_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [5:0] entry_index;
  logic [2:0] red_level;
  logic [2:0] green_level;
  logic [2:0] blue_level;

  modport source (
    output valid, mode, entry_index, red_level, green_level, blue_level,
    input  ready
  );
  modport sink (
    input  valid, mode, entry_index, red_level, green_level, blue_level,
    output ready
  );
endinterface

/* rtl/core/palfe_res_if.sv */
interface palfe_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] out_index;
  logic [2:0] red_out;
  logic [2:0] green_out;
  logic [2:0] blue_out;
  logic [2:0] red_alt_out;
  logic [2:0] green_alt_out;
  logic [2:0] blue_alt_out;
  logic       last_entry;
  logic       fade_done;

  modport source (
    output valid, out_index, red_out, green_out, blue_out,
           red_alt_out, green_alt_out, blue_alt_out, last_entry, fade_done,
    input  ready
  );
  modport sink (
    input  valid, out_index, red_out, green_out, blue_out,
           red_alt_out, green_alt_out, blue_alt_out, last_entry, fade_done,
    output ready
  );
endinterface

/* rtl/core/palfe_ctrl.sv */
`include "palette_fade_engine_unit_macros.svh"

module palfe_ctrl #(
  parameter int ENTRIES     = 64,
  parameter int FADE_FRAMES = 22,
  parameter int IW          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic [2:0]           cmd_mode,
  output logic                 cmd_ready,
  output palfe_pkg::ctrl_cmd_t cmd,
  output logic [IW-1:0]        addr,
  input  palfe_pkg::dp_status_t status
);
  import palfe_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  state_t               state;
  state_t               state_next;
  kind_t                kind;
  logic [FRAME_W-1:0]   frame_count;
  logic [FRAME_W-1:0]   frame_inc;
  logic [CW-1:0]        cnt;
  logic [LEVEL_W-1:0]   fill_level;
  kind_t                run_kind;
  logic                 run_done;
  logic                 accept;
  mode_t                mode;

  assign mode      = mode_t'(cmd_mode);
  assign accept    = cmd_valid && cmd_ready;
  assign frame_inc = frame_count + 5'd1;
  assign addr      = cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    cmd        = '0;
    cmd.fill_level = fill_level;
    cmd.run_kind   = run_kind;
    cmd.run_done   = run_done;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd.wr_target    = (mode == MODE_WR_TARGET);
          cmd.wr_primary   = (mode == MODE_WR_PRIMARY);
          cmd.wr_secondary = (mode == MODE_WR_SECONDARY);
          if (mode == MODE_FADE_IN || mode == MODE_FLASH_IN) state_next = ST_FILL;
          if (mode == MODE_TICK) state_next = ST_RUN;
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (cnt == CW'(ENTRIES - 1)) state_next = ST_IDLE;
      end
      ST_RUN: begin
        cmd.issue = (cnt < CW'(ENTRIES));
        if (status.last_taken) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind        <= KIND_IDLE;
      frame_count <= '0;
      cnt         <= '0;
      run_kind    <= KIND_IDLE;
      run_done    <= 1'b1;
    end else if (accept) begin
      cnt <= '0;
      case (mode)
        MODE_FADE_IN: begin
          kind        <= KIND_FADE_IN;
          frame_count <= '0;
        end
        MODE_FADE_OUT: begin
          kind        <= KIND_FADE_OUT;
          frame_count <= '0;
        end
        MODE_FLASH_IN: begin
          kind        <= KIND_FLASH_IN;
          frame_count <= '0;
        end
        MODE_FLASH_OUT: begin
          kind        <= KIND_FLASH_OUT;
          frame_count <= '0;
        end
        MODE_TICK: begin
          run_kind <= kind;
          if (kind == KIND_IDLE) begin
            run_done <= 1'b1;
          end else if (frame_inc >= FRAME_W'(FADE_FRAMES)) begin
            run_done    <= 1'b1;
            kind        <= KIND_IDLE;
            frame_count <= '0;
          end else begin
            run_done    <= 1'b0;
            frame_count <= frame_inc;
          end
        end
        default: ;
      endcase
    end else if (state == ST_FILL || (cmd.issue && status.advance)) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fill_level <= (mode == MODE_FLASH_IN) ? LEVEL_MAX : LEVEL_MIN;
    end
  end

  `PALFE_ASSERT(a_cnt_range, cnt <= CW'(ENTRIES))
  `PALFE_ASSERT(a_idle_count, (kind != KIND_IDLE) || (frame_count == '0))
  `PALFE_ASSERT_NEXT(a_run_ends, (state == ST_RUN) && status.last_taken, state == ST_IDLE)

endmodule

/* rtl/core/palfe_dp.sv */
`include "palette_fade_engine_unit_macros.svh"

module palfe_dp #(
  parameter int ENTRIES = 64,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  palfe_pkg::ctrl_cmd_t  cmd,
  input  logic [IW-1:0]         addr,
  input  logic [5:0]            entry_index,
  input  logic [2:0]            red_level,
  input  logic [2:0]            green_level,
  input  logic [2:0]            blue_level,
  output palfe_pkg::dp_status_t status,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [5:0]            out_index,
  output logic [2:0]            red_out,
  output logic [2:0]            green_out,
  output logic [2:0]            blue_out,
  output logic [2:0]            red_alt_out,
  output logic [2:0]            green_alt_out,
  output logic [2:0]            blue_alt_out,
  output logic                  last_entry,
  output logic                  fade_done
);
  import palfe_pkg::*;

  rgb_t target_mem    [ENTRIES];
  rgb_t primary_mem   [ENTRIES];
  rgb_t secondary_mem [ENTRIES];

  rgb_t          wr_data;
  rgb_t          fill_data;
  logic [IW-1:0] wr_idx;
  logic          idx_ok;
  logic          advance;
  logic          wb;
  logic          s1_valid;
  logic [IW-1:0] s1_idx;
  logic          s1_last;
  rgb_t          tgt_q;
  rgb_t          pri_q;
  rgb_t          sec_q;
  rgb_t          pri_new;
  rgb_t          sec_new;

  assign wr_data   = '{r: red_level, g: green_level, b: blue_level};
  assign fill_data = '{r: cmd.fill_level, g: cmd.fill_level, b: cmd.fill_level};
  assign wr_idx    = IW'(entry_index);
  assign idx_ok    = (32'(entry_index) < ENTRIES);
  assign advance   = !res_valid || res_ready;
  assign wb        = advance && s1_valid;
  assign s1_last   = (s1_idx == IW'(ENTRIES - 1));
  assign pri_new   = step_primary(cmd.run_kind, pri_q, tgt_q);
  assign sec_new   = step_secondary(cmd.run_kind, sec_q);

  assign status.advance    = advance;
  assign status.last_taken = wb && s1_last;

  always_ff @(posedge clk) begin
    if (cmd.wr_target && idx_ok) begin
      target_mem[wr_idx] <= wr_data;
    end
    if (cmd.issue && advance) begin
      tgt_q <= target_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_primary && idx_ok) begin
      primary_mem[wr_idx] <= wr_data;
    end else if (cmd.fill) begin
      primary_mem[addr] <= fill_data;
    end else if (wb) begin
      primary_mem[s1_idx] <= pri_new;
    end
    if (cmd.issue && advance) begin
      pri_q <= primary_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_secondary && idx_ok) begin
      secondary_mem[wr_idx] <= wr_data;
    end else if (wb) begin
      secondary_mem[s1_idx] <= sec_new;
    end
    if (cmd.issue && advance) begin
      sec_q <= secondary_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_idx <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wb) begin
      out_index     <= 6'(s1_idx);
      red_out       <= pri_new.r;
      green_out     <= pri_new.g;
      blue_out      <= pri_new.b;
      red_alt_out   <= sec_new.r;
      green_alt_out <= sec_new.g;
      blue_alt_out  <= sec_new.b;
      last_entry    <= s1_last;
      fade_done     <= cmd.run_done;
    end
  end

  `PALFE_ASSERT(a_fill_no_wb, !(cmd.fill && s1_valid))
  `PALFE_ASSERT_NEXT(a_s1_hold, s1_valid && !advance, s1_valid && $stable(s1_idx))
  `PALFE_ASSERT_NEXT(a_wb_emits, wb, res_valid)

endmodule

/* rtl/core/palette_fade_engine_unit.sv */
// Palette fader with target, primary and secondary palettes of 3-bit RGB levels.
// cmd channel (valid/ready): one item writes an entry of a palette, starts one
// of the four fades, or gives a frame tick, selected by mode.
// result channel (valid/ready): each tick yields ENTRIES items, one per entry
// from index 0 upward, carrying the primary and secondary levels after the
// step; last_entry marks the final one and fade_done is the same in all of them.
// Writes and fade-out/flash-out starts leave the engine idle. Fade-in and flash-in
// starts sweep the primary palette before the next item is taken.
// A tick reads each entry from the palette memories through a registered read
// port; the read stage and then the output register carry each entry to the
// result channel, one result per cycle while the receiver is ready.
// A stalled receiver holds the output register and the read stage; the entry
// sweep pauses and resumes without loss.
// Reset clears the fade to idle and the frame count; palette contents are
// undefined until written.
module palette_fade_engine_unit #(
  parameter int ENTRIES     = 64,
  parameter int FADE_FRAMES = 22
) (
  input  logic        clk,
  input  logic        rst,
  palfe_cmd_if.sink   cmd,
  palfe_res_if.source result
);
  import palfe_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ctrl_cmd_t     ctrl;
  dp_status_t    status;
  logic [IW-1:0] addr;

  palfe_ctrl #(
    .ENTRIES     (ENTRIES),
    .FADE_FRAMES (FADE_FRAMES),
    .IW          (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_mode  (cmd.mode),
    .cmd_ready (cmd.ready),
    .cmd       (ctrl),
    .addr      (addr),
    .status    (status)
  );

  palfe_dp #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctrl),
    .addr          (addr),
    .entry_index   (cmd.entry_index),
    .red_level     (cmd.red_level),
    .green_level   (cmd.green_level),
    .blue_level    (cmd.blue_level),
    .status        (status),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .out_index     (result.out_index),
    .red_out       (result.red_out),
    .green_out     (result.green_out),
    .blue_out      (result.blue_out),
    .red_alt_out   (result.red_alt_out),
    .green_alt_out (result.green_alt_out),
    .blue_alt_out  (result.blue_alt_out),
    .last_entry    (result.last_entry),
    .fade_done     (result.fade_done)
  );

endmodule

/* tb/tb_palette_fade_engine_unit.sv */
module tb_palette_fade_engine_unit;
  import palfe_pkg::*;

  localparam int ENTRIES = 64;
  localparam int FADE_FRAMES = 22;
  localparam int RANDOM_ITEMS = 40;
  localparam int QUIET_ITEMS = 15;
  localparam int SETTLE_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [5:0] entry_idx;
    rgb_t       prim;
    rgb_t       alt;
    logic       last;
    logic       done;
  } entry_report_t;

  class fade_checker;
    rgb_t          target_pal[ENTRIES];
    rgb_t          primary_pal[ENTRIES];
    rgb_t          secondary_pal[ENTRIES];
    kind_t         fade_state;
    int            frames_done;
    entry_report_t expected_reports[$];
    int            errors;
    int            reports_seen;
    int            frames_reported;
    int            fades_finished;

    function new();
      fade_state = KIND_IDLE;
      frames_done = 0;
      errors = 0;
      reports_seen = 0;
      frames_reported = 0;
      fades_finished = 0;
    endfunction

    function rgb_t move_out(rgb_t cur, bit to_white);
      rgb_t nxt;
      nxt = cur;
      if (to_white) begin
        if (cur.r != LEVEL_MAX) nxt.r = cur.r + 3'd1;
        else if (cur.g != LEVEL_MAX) nxt.g = cur.g + 3'd1;
        else if (cur.b != LEVEL_MAX) nxt.b = cur.b + 3'd1;
      end else begin
        if (cur.r != LEVEL_MIN) nxt.r = cur.r - 3'd1;
        else if (cur.g != LEVEL_MIN) nxt.g = cur.g - 3'd1;
        else if (cur.b != LEVEL_MIN) nxt.b = cur.b - 3'd1;
      end
      return nxt;
    endfunction

    function void note_item(mode_t mode, logic [5:0] idx, rgb_t lvl);
      rgb_t          cur;
      rgb_t          goal;
      bit            done;
      entry_report_t rep;
      case (mode)
        MODE_WR_TARGET: target_pal[idx] = lvl;
        MODE_WR_PRIMARY: primary_pal[idx] = lvl;
        MODE_WR_SECONDARY: secondary_pal[idx] = lvl;
        MODE_FADE_IN, MODE_FLASH_IN: begin
          for (int i = 0; i < ENTRIES; i++) begin
            primary_pal[i] = (mode == MODE_FADE_IN) ? {3{LEVEL_MIN}} : {3{LEVEL_MAX}};
          end
          fade_state = (mode == MODE_FADE_IN) ? KIND_FADE_IN : KIND_FLASH_IN;
          frames_done = 0;
        end
        MODE_FADE_OUT: begin
          fade_state = KIND_FADE_OUT;
          frames_done = 0;
        end
        MODE_FLASH_OUT: begin
          fade_state = KIND_FLASH_OUT;
          frames_done = 0;
        end
        default: begin
          if (fade_state == KIND_IDLE) begin
            done = 1'b1;
          end else begin
            for (int i = 0; i < ENTRIES; i++) begin
              cur = primary_pal[i];
              goal = target_pal[i];
              case (fade_state)
                KIND_FADE_IN: begin
                  if (goal.b > cur.b) cur.b = cur.b + 3'd1;
                  else if (goal.g > cur.g) cur.g = cur.g + 3'd1;
                  else if (goal.r > cur.r) cur.r = cur.r + 3'd1;
                  primary_pal[i] = cur;
                end
                KIND_FLASH_IN: begin
                  if (goal.b < cur.b) cur.b = cur.b - 3'd1;
                  else if (goal.g < cur.g) cur.g = cur.g - 3'd1;
                  else if (goal.r < cur.r) cur.r = cur.r - 3'd1;
                  primary_pal[i] = cur;
                end
                default: begin
                  primary_pal[i] = move_out(cur, fade_state == KIND_FLASH_OUT);
                  secondary_pal[i] = move_out(secondary_pal[i], fade_state == KIND_FLASH_OUT);
                end
              endcase
            end
            frames_done++;
            done = (frames_done >= FADE_FRAMES);
            if (done) begin
              frames_done = 0;
              fade_state = KIND_IDLE;
              fades_finished++;
            end
          end
          for (int i = 0; i < ENTRIES; i++) begin
            rep.entry_idx = 6'(i);
            rep.prim = primary_pal[i];
            rep.alt = secondary_pal[i];
            rep.last = (i == ENTRIES - 1);
            rep.done = done;
            expected_reports.push_back(rep);
          end
          frames_reported++;
        end
      endcase
    endfunction

    function void check_field(string name, int idx, int want, int got);
      if (want != got) begin
        $display("%0t: entry %0d %s expected %0d actual %0d", $time, idx, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(entry_report_t got);
      entry_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected entry report, expected none actual index %0d",
                 $time, got.entry_idx);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      reports_seen++;
      check_field("out_index", int'(want.entry_idx), int'(want.entry_idx),
                  int'(got.entry_idx));
      check_field("red_out", int'(want.entry_idx), int'(want.prim.r), int'(got.prim.r));
      check_field("green_out", int'(want.entry_idx), int'(want.prim.g), int'(got.prim.g));
      check_field("blue_out", int'(want.entry_idx), int'(want.prim.b), int'(got.prim.b));
      check_field("red_alt_out", int'(want.entry_idx), int'(want.alt.r), int'(got.alt.r));
      check_field("green_alt_out", int'(want.entry_idx), int'(want.alt.g), int'(got.alt.g));
      check_field("blue_alt_out", int'(want.entry_idx), int'(want.alt.b), int'(got.alt.b));
      check_field("last_entry", int'(want.entry_idx), int'(want.last), int'(got.last));
      check_field("fade_done", int'(want.entry_idx), int'(want.done), int'(got.done));
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic quiet = 1'b0;
  int stall_left = 0;
  int unsigned cycles = 0;
  int items_sent = 0;
  int random_items;
  int tick_count;
  int burst;

  fade_checker chk = new();

  palfe_cmd_if cmd_ch ();
  palfe_res_if res_ch ();

  palette_fade_engine_unit #(
    .ENTRIES    (ENTRIES),
    .FADE_FRAMES(FADE_FRAMES)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_ch),
    .result(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d entry reports outstanding", $time, chk.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 23) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_monitor
    entry_report_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.entry_idx = res_ch.out_index;
      got.prim = {res_ch.red_out, res_ch.green_out, res_ch.blue_out};
      got.alt = {res_ch.red_alt_out, res_ch.green_alt_out, res_ch.blue_alt_out};
      got.last = res_ch.last_entry;
      got.done = res_ch.fade_done;
      chk.check_result(got);
    end
  end

  task automatic send_item(mode_t mode, logic [5:0] idx, logic [2:0] r, logic [2:0] g,
                           logic [2:0] b);
    rgb_t lvl;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= mode;
    cmd_ch.entry_index <= idx;
    cmd_ch.red_level <= r;
    cmd_ch.green_level <= g;
    cmd_ch.blue_level <= b;
    do @(posedge clk); while (!cmd_ch.ready);
    lvl.r = r;
    lvl.g = g;
    lvl.b = b;
    chk.note_item(mode, idx, lvl);
    items_sent++;
  endtask

  task automatic send_noisy(mode_t mode);
    send_item(mode, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
              3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= MODE_WR_TARGET;
    cmd_ch.entry_index <= '0;
    cmd_ch.red_level <= '0;
    cmd_ch.green_level <= '0;
    cmd_ch.blue_level <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // load every entry of all three palettes, black at the bottom, white at the top
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (i == 0)
          send_item(mode_t'(p), 6'(i), LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        else if (i == ENTRIES - 1)
          send_item(mode_t'(p), 6'(i), LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        else
          send_item(mode_t'(p), 6'(i), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)));
      end
    end

    send_noisy(MODE_TICK);
    send_noisy(MODE_FADE_IN);
    send_noisy(MODE_TICK);
    send_item(MODE_WR_TARGET, 6'(ENTRIES - 1), LEVEL_MAX, LEVEL_MIN, LEVEL_MAX);
    send_noisy(MODE_FLASH_IN);
    send_noisy(MODE_TICK);
    send_noisy(MODE_FLASH_OUT);
    send_noisy(MODE_TICK);
    send_noisy(MODE_FADE_OUT);
    repeat (FADE_FRAMES + 2) send_noisy(MODE_TICK);
    wait_drained();

    random_items = 0;
    while (random_items < RANDOM_ITEMS - QUIET_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_noisy(mode_t'($urandom_range(0, 7)));
        random_items += burst;
      end else begin
        send_noisy(mode_t'($urandom_range(MODE_FADE_IN, MODE_FLASH_OUT)));
        random_items++;
        if ($urandom_range(0, 9) < 7)
          tick_count = $urandom_range(FADE_FRAMES, FADE_FRAMES + 4);
        else
          tick_count = $urandom_range(1, FADE_FRAMES - 1);
        while (tick_count > 0) begin
          if ($urandom_range(0, 5) == 0) begin
            send_noisy(mode_t'($urandom_range(MODE_WR_TARGET, MODE_WR_SECONDARY)));
          end else begin
            send_noisy(MODE_TICK);
            tick_count--;
          end
          random_items++;
        end
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    quiet <= 1'b1;
    repeat (16) @(posedge clk);
    repeat (QUIET_ITEMS) send_noisy(mode_t'($urandom_range(0, 7)));
    random_items += QUIET_ITEMS;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d palette frames, %0d fades run to completion.",
             items_sent, chk.frames_reported, chk.fades_finished);
    $display("Checked %0d entry reports, %0d field mismatches.", chk.reports_seen, chk.errors);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
